>>> hdl/led_grayscale_frame_and_latch_timer_defines.svh
// Assertion macros for the grayscale frame and latch timer.
`ifndef LED_GRAYSCALE_FRAME_AND_LATCH_TIMER_DEFINES_SVH
`define LED_GRAYSCALE_FRAME_AND_LATCH_TIMER_DEFINES_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define LGFLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked property that also holds during reset.
`define LGFLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LGFLT_ASSERT(lbl, prop, msg)
`define LGFLT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/lgflt_pkg.sv
// Package with constants and types of the grayscale frame and latch timer.
package lgflt_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  // Command codes of an input beat.
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_SEND = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PULSE_STEP  = 2'd0;
  localparam logic [1:0] REG_PULSE_LIMIT = 2'd1;
  localparam logic [1:0] REG_CYCLE_LIMIT = 2'd2;

  // Register reset values.
  localparam logic [7:0]  PULSE_STEP_RST  = 8'd64;
  localparam logic [15:0] PULSE_LIMIT_RST = 16'd4096;
  localparam logic [15:0] CYCLE_LIMIT_RST = 16'd1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SET  = 3'b010,
    ST_SEND = 3'b100
  } state_e;

endpackage

>>> hdl/led_grayscale_frame_and_latch_timer.sv
// Top level of the grayscale frame and latch timer for a 16-channel LED driver.
//
// Usage: the input channel carries one command per beat (set a channel level, send
// the frame, or a timer tick). The output channel carries frame bytes and tick events.
// The frame lives in a 24-byte circular shift register that turns by one byte per
// cycle during a set or send pass (a send holds while the receiver stalls), so only
// the byte at its head is ever read or modified.
// A set command stalls the input after its beat is taken while the frame makes one full
// turn and the two bytes that hold the channel are rewritten as they pass the head.
// Sets to channels above fifteen and the unused command code change nothing.
// A send command stalls the input until the frame has made one full turn: each one-byte
// turn of the ring emits one byte beat, the last one marked, and the latch is re-armed.
// A tick does not occupy the sequencer; its event beat is registered. Results sit in
// one output register, so a new beat is taken while a result waits, as long as the
// register is freed at the same edge. While the receiver stalls a waiting result,
// input beats are stalled and a send's ring and sequencer hold; a set pass runs on.
// Reset clears the frame to zeros, the counters to zero, arms the latch and loads
// the register defaults (step 64, pulse limit 4096, cycle limit 1).
// Registers are to be written over the APB-style port only while the block is idle;
// the block itself does not enforce it.
`include "led_grayscale_frame_and_latch_timer_defines.svh"

module led_grayscale_frame_and_latch_timer #(
  parameter int FrameBytes = lgflt_pkg::FRAME_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB-style configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgflt_pkg::ADDR_W-1:0]  paddr,
  input  logic [lgflt_pkg::DATA_W-1:0]  pwdata,
  output logic [lgflt_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  // Command input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    in_command_i,
  input  logic [7:0]                    in_channel_i,
  input  logic [11:0]                   in_level_i,
  // Result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_kind_o,
  output logic [7:0]                    out_frame_byte_o,
  output logic                          out_last_byte_o,
  output logic                          out_blank_pulse_o,
  output logic                          out_latch_pulse_o
);

  localparam int IdxW = $clog2(FrameBytes);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameBytes - 1);

  // Configuration registers.
  logic [7:0]  pulse_step_q;
  logic [15:0] pulse_limit_q;
  logic [15:0] cycle_limit_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_step_q  <= lgflt_pkg::PULSE_STEP_RST;
      pulse_limit_q <= lgflt_pkg::PULSE_LIMIT_RST;
      cycle_limit_q <= lgflt_pkg::CYCLE_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        lgflt_pkg::REG_PULSE_STEP:  pulse_step_q  <= pwdata[7:0];
        lgflt_pkg::REG_PULSE_LIMIT: pulse_limit_q <= pwdata[15:0];
        lgflt_pkg::REG_CYCLE_LIMIT: cycle_limit_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      lgflt_pkg::REG_PULSE_STEP:  prdata = {24'd0, pulse_step_q};
      lgflt_pkg::REG_PULSE_LIMIT: prdata = {16'd0, pulse_limit_q};
      lgflt_pkg::REG_CYCLE_LIMIT: prdata = {16'd0, cycle_limit_q};
      default:                    prdata = '0;
    endcase
  end

  // Sequencer, frame ring and timer state.
  lgflt_pkg::state_e state_q, state_d;
  logic [FrameBytes-1:0][7:0] frame_q, frame_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            odd_q, odd_d;
  logic [11:0]     level_q, level_d;
  logic [16:0]     pulse_cnt_q, pulse_cnt_d;
  logic [15:0]     cycle_cnt_q, cycle_cnt_d;
  logic            armed_q, armed_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  logic       kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       blank_q, blank_d;
  logic       latch_q, latch_d;

  logic        out_free;
  logic        in_accept;
  logic [7:0]  head;
  logic [7:0]  head_new;
  logic [IdxW-1:0] pos_next;
  logic [3:0]  rev_ch;
  logic [5:0]  pos_sum;
  logic [16:0] pulse_sum;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != lgflt_pkg::ST_IDLE) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign head       = frame_q[0];
  assign pos_next   = pos_q + IdxW'(1);

  // First byte touched by a channel: ((15 - ch) * 3) / 2.
  assign rev_ch  = ~in_channel_i[3:0];
  assign pos_sum = {1'b0, rev_ch, 1'b0} + {2'b00, rev_ch};
  assign pulse_sum = pulse_cnt_q + {9'd0, pulse_step_q};

  // Byte merge at the ring head during a set pass.
  always_comb begin
    head_new = head;
    if (idx_q == pos_q) begin
      head_new = odd_q ? level_q[11:4] : {head[7:4], level_q[11:8]};
    end else if (idx_q == pos_next) begin
      head_new = odd_q ? {level_q[3:0], head[3:0]} : level_q[7:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    odd_d       = odd_q;
    level_d     = level_q;
    pulse_cnt_d = pulse_cnt_q;
    cycle_cnt_d = cycle_cnt_q;
    armed_d     = armed_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    byte_d      = byte_q;
    last_d      = last_q;
    blank_d     = blank_q;
    latch_d     = latch_q;

    case (state_q)
      lgflt_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_command_i)
            lgflt_pkg::CMD_SET: begin
              if (in_channel_i[7:4] == 4'd0) begin
                state_d = lgflt_pkg::ST_SET;
                idx_d   = '0;
                pos_d   = IdxW'(pos_sum[5:1]);
                odd_d   = in_channel_i[0];
                level_d = in_level_i;
              end
            end
            lgflt_pkg::CMD_SEND: begin
              state_d = lgflt_pkg::ST_SEND;
              idx_d   = '0;
              armed_d = 1'b1;
            end
            lgflt_pkg::CMD_TICK: begin
              out_valid_d = 1'b1;
              kind_d      = 1'b1;
              byte_d      = '0;
              last_d      = 1'b0;
              blank_d     = 1'b0;
              latch_d     = 1'b0;
              pulse_cnt_d = pulse_sum;
              if (pulse_sum > {1'b0, pulse_limit_q}) begin
                blank_d     = 1'b1;
                pulse_cnt_d = '0;
                if (cycle_cnt_q < cycle_limit_q) begin
                  cycle_cnt_d = cycle_cnt_q + 16'd1;
                end else begin
                  cycle_cnt_d = '0;
                  if (armed_q) begin
                    latch_d = 1'b1;
                    armed_d = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      lgflt_pkg::ST_SET: begin
        frame_d = {head_new, frame_q[FrameBytes-1:1]};
        idx_d   = idx_q + IdxW'(1);
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = lgflt_pkg::ST_IDLE;
        end
      end
      lgflt_pkg::ST_SEND: begin
        if (out_free) begin
          frame_d     = {head, frame_q[FrameBytes-1:1]};
          out_valid_d = 1'b1;
          kind_d      = 1'b0;
          byte_d      = head;
          last_d      = (idx_q == LastIdx);
          blank_d     = 1'b0;
          latch_d     = 1'b0;
          idx_d       = idx_q + IdxW'(1);
          if (idx_q == LastIdx) begin
            idx_d   = '0;
            state_d = lgflt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lgflt_pkg::ST_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgflt_pkg::ST_IDLE;
      frame_q     <= '0;
      idx_q       <= '0;
      pulse_cnt_q <= '0;
      cycle_cnt_q <= '0;
      armed_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      frame_q     <= frame_d;
      idx_q       <= idx_d;
      pulse_cnt_q <= pulse_cnt_d;
      cycle_cnt_q <= cycle_cnt_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    odd_q   <= odd_d;
    level_q <= level_d;
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
    blank_q <= blank_d;
    latch_q <= latch_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_kind_o        = kind_q;
  assign out_frame_byte_o  = byte_q;
  assign out_last_byte_o   = last_q;
  assign out_blank_pulse_o = blank_q;
  assign out_latch_pulse_o = latch_q;

  // A latch pulse is only issued at the end of a PWM period.
  `LGFLT_ASSERT(a_latch_with_blank, (out_valid_q && latch_q) |-> blank_q, "latch pulse without blank")
  // Disarming the latch always goes with a latch event in the output register.
  `LGFLT_ASSERT(a_disarm_emits, $fell(armed_q) |-> (out_valid_q && latch_q && kind_q), "disarm without latch beat")
  // The final byte beat of a send returns the sequencer to idle.
  `LGFLT_ASSERT(a_send_ends, (state_q == lgflt_pkg::ST_SEND && idx_q == LastIdx && out_free) |=> (state_q == lgflt_pkg::ST_IDLE && out_valid_q && last_q), "send did not end on last byte")

endmodule

>>> tb/led_grayscale_frame_and_latch_timer_tb.sv
// Self-checking testbench for the grayscale frame and latch timer: directed and random commands.
module led_grayscale_frame_and_latch_timer_tb;

  // The command code that the block must ignore, and a register index past the map.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Values of the kind field of a result beat.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // This bound only catches a hang.
  localparam int RUN_LIMIT        = 2_000_000;
  // A set command keeps the ring busy for a full turn without producing a beat, so the
  // idle wait before a register write covers one turn plus some margin.
  localparam int DRAIN_CYCLES     = lgflt_pkg::FRAME_BYTES + 8;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS      = 84;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       blank_pulse;
    logic       latch_pulse;
  } result_beat_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_ALTERNATE
  } stall_mode_e;

  // The scoreboard keeps its own copy of the frame, the timer state and the registers.
  // Every accepted command updates that copy and queues the beats it must cause; every
  // accepted result beat is compared with the oldest queued one.
  class frame_timer_scoreboard;
    logic [7:0]   frame_bytes [lgflt_pkg::FRAME_BYTES];
    logic [16:0]  pulse_count;
    logic [15:0]  period_count;
    logic         latch_armed;
    logic [7:0]   step_reg;
    logic [15:0]  pulse_limit_reg;
    logic [15:0]  cycle_limit_reg;
    result_beat_t expected_beats[$];
    int           mismatches;

    function new();
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      pulse_count     = '0;
      period_count    = '0;
      latch_armed     = 1'b1;
      step_reg        = lgflt_pkg::PULSE_STEP_RST;
      pulse_limit_reg = lgflt_pkg::PULSE_LIMIT_RST;
      cycle_limit_reg = lgflt_pkg::CYCLE_LIMIT_RST;
      mismatches      = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Only the low bits of each register count; an unmapped index changes nothing.
    function void write_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        lgflt_pkg::REG_PULSE_STEP:  step_reg        = value[7:0];
        lgflt_pkg::REG_PULSE_LIMIT: pulse_limit_reg = value[15:0];
        lgflt_pkg::REG_CYCLE_LIMIT: cycle_limit_reg = value[15:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic [1:0] cmd, logic [7:0] chan, logic [11:0] level);
      result_beat_t beat;
      int           pos;
      beat = '0;
      case (cmd)
        lgflt_pkg::CMD_SET: begin
          // Channel 15 sits at the front of the frame. Odd channels start on a byte
          // boundary, even channels start in the low nibble of their first byte.
          if (chan <= 8'd15) begin
            pos = ((15 - int'(chan)) * 3) / 2;
            if (chan[0]) begin
              frame_bytes[pos]     = level[11:4];
              frame_bytes[pos + 1] = {level[3:0], frame_bytes[pos + 1][3:0]};
            end else begin
              frame_bytes[pos]     = {frame_bytes[pos][7:4], level[11:8]};
              frame_bytes[pos + 1] = level[7:0];
            end
          end
        end
        lgflt_pkg::CMD_SEND: begin
          for (int i = 0; i < lgflt_pkg::FRAME_BYTES; i++) begin
            beat.kind       = KIND_BYTE;
            beat.frame_byte = frame_bytes[i];
            beat.last_byte  = (i == lgflt_pkg::FRAME_BYTES - 1);
            expected_beats.push_back(beat);
          end
          latch_armed = 1'b1;
        end
        lgflt_pkg::CMD_TICK: begin
          beat.kind   = KIND_TICK;
          pulse_count = pulse_count + 17'(step_reg);
          if (pulse_count > {1'b0, pulse_limit_reg}) begin
            beat.blank_pulse = 1'b1;
            if (period_count < cycle_limit_reg) begin
              period_count = period_count + 16'd1;
            end else begin
              if (latch_armed) begin
                beat.latch_pulse = 1'b1;
                latch_armed      = 1'b0;
              end
              period_count = '0;
            end
            pulse_count = '0;
          end
          expected_beats.push_back(beat);
        end
        default: ;
      endcase
    endfunction

    function string beat_text(result_beat_t b);
      return $sformatf("kind=%0b byte=%02h last=%0b blank=%0b latch=%0b",
                       b.kind, b.frame_byte, b.last_byte, b.blank_pulse, b.latch_pulse);
    endfunction

    function void check_beat(result_beat_t got);
      result_beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: %s", beat_text(got));
        return;
      end
      want = expected_beats.pop_front();
      if (got.kind !== want.kind || got.frame_byte !== want.frame_byte ||
          got.last_byte !== want.last_byte || got.blank_pulse !== want.blank_pulse ||
          got.latch_pulse !== want.latch_pulse) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %s, got %s", beat_text(want), beat_text(got));
      end
    endfunction
  endclass

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           psel         = 1'b0;
  logic                           penable      = 1'b0;
  logic                           pwrite       = 1'b0;
  logic [lgflt_pkg::ADDR_W-1:0]   paddr        = '0;
  logic [lgflt_pkg::DATA_W-1:0]   pwdata       = '0;
  logic [lgflt_pkg::DATA_W-1:0]   prdata;
  logic                           pready;
  logic                           in_valid_i   = 1'b0;
  logic                           in_stall_o;
  logic [1:0]                     in_command_i = lgflt_pkg::CMD_SET;
  logic [7:0]                     in_channel_i = '0;
  logic [11:0]                    in_level_i   = '0;
  logic                           out_valid_o;
  logic                           out_stall_i  = 1'b0;
  logic                           out_kind_o;
  logic [7:0]                     out_frame_byte_o;
  logic                           out_last_byte_o;
  logic                           out_blank_pulse_o;
  logic                           out_latch_pulse_o;

  // Handshake between the stimulus and the receiver process: hold_req asks for one long
  // hold-off, drain_quiet keeps the receiver ready while the block is being emptied.
  bit                   hold_req     = 1'b0;
  bit                   drain_quiet  = 1'b0;
  int                   cycle_count  = 0;

  frame_timer_scoreboard sb;

  led_grayscale_frame_and_latch_timer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_command_i     (in_command_i),
    .in_channel_i     (in_channel_i),
    .in_level_i       (in_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .out_frame_byte_o (out_frame_byte_o),
    .out_last_byte_o  (out_last_byte_o),
    .out_blank_pulse_o(out_blank_pulse_o),
    .out_latch_pulse_o(out_latch_pulse_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hang guard. It counts every clock from the start, reset included.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("[led_grayscale_frame_and_latch_timer] ERROR");
      $finish;
    end
  end

  // Result monitor. Outputs are sampled at the rising edge, where a beat moves only if
  // valid is high and this side does not stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_beat({out_kind_o, out_frame_byte_o, out_last_byte_o,
                     out_blank_pulse_o, out_latch_pulse_o});
  end

  // Receiver. It runs in segments of random length, each with its own stall pattern:
  // never, now and then, mostly, or alternating. On request it holds off for a long
  // stretch so that the result register stays full and the block must stall its input.
  initial begin : receiver_pattern
    int          seg_len;
    int          hold;
    stall_mode_e mode;
    forever begin
      seg_len = $urandom_range(4, 60);
      mode    = stall_mode_e'($urandom_range(0, 3));
      for (int c = 0; c < seg_len && !hold_req; c++) begin
        @(negedge clk_i);
        if (drain_quiet) begin
          out_stall_i <= 1'b0;
        end else begin
          case (mode)
            STALL_NONE:  out_stall_i <= 1'b0;
            STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
            default:     out_stall_i <= c[0];
          endcase
        end
      end
      if (hold_req) begin
        for (hold = 0; hold < LONG_HOLD_CYCLES; hold++) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
        hold_req = 1'b0;
      end
    end
  end

  // Offers one command beat and waits until it is taken. Valid stays high on return, so
  // a following beat in the same burst goes out without a bubble.
  task automatic drive_beat(logic [1:0] cmd, logic [7:0] chan, logic [11:0] level);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    in_command_i <= cmd;
    in_channel_i <= chan;
    in_level_i   <= level;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(cmd, chan, level);
  endtask

  task automatic idle_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Two-phase register write: setup, then access; the register takes the value at the
  // edge where the access phase sees pready high.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Lets the block run empty: every queued beat must have come, and then the ring gets
  // time to finish a set that produces no beat. The receiver stays ready meanwhile.
  task automatic wait_idle();
    idle_gap(1);
    drain_quiet = 1'b1;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Upper data bits are filled with noise; only the register's own width must count.
  task automatic configure(logic [7:0] step, logic [15:0] plimit, logic [15:0] climit);
    wait_idle();
    reg_write(lgflt_pkg::REG_PULSE_STEP,  {24'($urandom), step});
    reg_write(lgflt_pkg::REG_PULSE_LIMIT, {16'($urandom), plimit});
    reg_write(lgflt_pkg::REG_CYCLE_LIMIT, {16'($urandom), climit});
    drain_quiet = 1'b0;
  endtask

  // Random commands in bursts with random gaps. Ticks and sets to real channels make up
  // most of the mix; sends are rarer since each one walks the whole frame. Ignored beats
  // (the unused code, sets past channel fifteen) are sent but not counted.
  task automatic run_random_items(int count);
    int         left;
    int         burst;
    int         pick;
    logic [1:0] cmd;
    logic [7:0] chan;
    logic [11:0] level;
    left = count;
    while (left > 0) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int b = 0; b < burst && left > 0; b++) begin
        pick  = $urandom_range(0, 99);
        chan  = 8'($urandom_range(0, 255));
        level = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 7) == 0)
          level = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        if (pick < 45) begin
          cmd = lgflt_pkg::CMD_TICK;
        end else if (pick < 85) begin
          cmd = lgflt_pkg::CMD_SET;
          if (pick < 80) chan = {4'h0, chan[3:0]};
        end else if (pick < 95) begin
          cmd = lgflt_pkg::CMD_SEND;
        end else begin
          cmd = CMD_UNUSED;
        end
        drive_beat(cmd, chan, level);
        if (cmd != CMD_UNUSED && !(cmd == lgflt_pkg::CMD_SET && chan > 8'd15)) left--;
      end
      idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10));
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults. Both ends of the channel range with full-scale levels, the neighbor of
    // each end with a distinct pattern so that shared nibbles show up, a zero level, and
    // sets past channel fifteen plus the unused code, all of which must leave the frame
    // alone. The send then shows the whole frame.
    drive_beat(lgflt_pkg::CMD_SET, 8'd15, 12'hFFF);
    drive_beat(lgflt_pkg::CMD_SET, 8'd0, 12'hFFF);
    drive_beat(lgflt_pkg::CMD_SET, 8'd14, 12'hA5C);
    drive_beat(lgflt_pkg::CMD_SET, 8'd1, 12'h123);
    drive_beat(lgflt_pkg::CMD_SET, 8'd7, 12'h000);
    drive_beat(lgflt_pkg::CMD_SET, 8'd16, 12'hFFF);
    drive_beat(lgflt_pkg::CMD_SET, 8'd255, 12'h5A5);
    drive_beat(CMD_UNUSED, 8'hFF, 12'hFFF);
    drive_beat(lgflt_pkg::CMD_SEND, 8'h00, 12'h000);
    repeat (3) drive_beat(lgflt_pkg::CMD_TICK, 8'($urandom), 12'($urandom));

    // Largest step against zero limits: every tick blanks, the first one latches, and
    // the latch stays off until a send re-arms it.
    configure(8'd255, 16'd0, 16'd0);
    repeat (3) drive_beat(lgflt_pkg::CMD_TICK, 8'($urandom), 12'($urandom));
    drive_beat(lgflt_pkg::CMD_SEND, 8'($urandom), 12'($urandom));
    drive_beat(lgflt_pkg::CMD_TICK, 8'($urandom), 12'($urandom));

    // A zero step keeps the pulse counter where it is, so nothing blanks. A write to the
    // unmapped index must not disturb any register.
    configure(8'd0, 16'd0, 16'd0);
    reg_write(REG_UNUSED, $urandom);
    repeat (2) drive_beat(lgflt_pkg::CMD_TICK, 8'($urandom), 12'($urandom));

    // Random phases, each under its own settings: the low extremes, a moderate period,
    // a random short one with the long receiver hold-off, the high extremes where no
    // period ever ends, and one more random mix.
    configure(8'd255, 16'd0, 16'd0);
    run_random_items(PHASE_ITEMS);

    configure(8'd200, 16'd4096, 16'd1);
    run_random_items(PHASE_ITEMS);

    configure(8'($urandom_range(100, 255)), 16'($urandom_range(0, 2000)),
              16'($urandom_range(0, 3)));
    hold_req = 1'b1;
    run_random_items(PHASE_ITEMS);

    configure(8'd1, 16'd65535, 16'd65535);
    run_random_items(PHASE_ITEMS);

    configure(8'($urandom_range(1, 255)), 16'($urandom_range(0, 1000)),
              16'($urandom_range(0, 2)));
    run_random_items(PHASE_ITEMS);

    wait_idle();
    if (sb.mismatches == 0) begin
      $display("[led_grayscale_frame_and_latch_timer] OK");
    end else begin
      $display("[led_grayscale_frame_and_latch_timer] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/lgflt_pkg.sv
hdl/led_grayscale_frame_and_latch_timer.sv
tb/led_grayscale_frame_and_latch_timer_tb.sv
